>>> hdl/drps_pkg.sv
package drps_pkg;

	// Fixed number formats
	localparam int ANGLE_BITS = 32;
	localparam int FRAC_BITS = ANGLE_BITS - 2;
	localparam int DW = 40;
	localparam int CORDIC_STEPS_DEF = 32;
	localparam int ITER_W = 6;

	localparam logic [15:0] GAIN_RESET = 16'd14131;
	localparam logic signed [DW-1:0] HALF_TURN = DW'(64'h8000_0000);
	localparam logic signed [DW-1:0] QUARTER_TURN = DW'(64'h4000_0000);
	localparam logic signed [DW-1:0] NEG_QUARTER_TURN = -QUARTER_TURN;
	// inverse CORDIC gain, Q30
	localparam logic signed [DW-1:0] KINV = DW'(64'h26DD_3B6A);
	localparam logic [63:0] INV_PI_Q64 = 64'h517C_C1B7_2722_0A94;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_PREP,
		OP_ROT_INIT,
		OP_ITER,
		OP_ROT_DONE,
		OP_MUL,
		OP_MUL_WR,
		OP_VEC_INIT,
		OP_VEC_DONE,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
		logic [2:0] sel;
		logic [ITER_W-1:0] iter;
	} drps_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_ROT_INIT,
		ST_ROT_ITER,
		ST_ROT_DONE,
		ST_MUL,
		ST_MUL_WR,
		ST_VEC_INIT,
		ST_VEC_ITER,
		ST_VEC_DONE,
		ST_OUT
	} state_t;

	// atan(2^-i) as a binary angle, from the truncated series times 1/pi
	function automatic logic signed [DW-1:0] atan_entry(input int i);
		logic [63:0] acc;
		logic [63:0] term;
		logic [63:0] num;
		logic [63:0] rem;
		logic [127:0] prod;
		int m;
		bit done;
		acc = '0;
		done = 1'b0;
		if (i == 0) begin
			return QUARTER_TURN >>> 1;
		end
		for (int k = 0; k < 64; k++) begin
			m = 2 * k + 1;
			if (!done && (i * m <= 62)) begin
				num = 64'd1 << (62 - i * m);
				rem = '0;
				term = '0;
				// restoring long division by m
				for (int b = 63; b >= 0; b--) begin
					rem = {rem[62:0], num[b]};
					if (rem >= 64'(m)) begin
						rem = rem - 64'(m);
						term[b] = 1'b1;
					end
				end
				if (k % 2 == 1) acc = acc - term;
				else acc = acc + term;
			end else begin
				done = 1'b1;
			end
		end
		prod = {64'd0, acc} * {64'd0, INV_PI_Q64};
		return DW'(prod[127:95]);
	endfunction

endpackage

>>> hdl/drps_ctrl.sv
module drps_ctrl #(
	parameter int CORDIC_STEPS = drps_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_tick,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output drps_pkg::drps_cmd_t cmd
);
	import drps_pkg::*;

	localparam int IW = $clog2(CORDIC_STEPS);
	localparam logic [IW-1:0] LAST_ITER = IW'(CORDIC_STEPS - 1);
	localparam logic [2:0] PH_SINCOS_LAST = 3'd2;
	localparam logic [2:0] PH_MUL_W = 3'd5;
	localparam logic [2:0] PH_MUL_HM = 3'd6;

	state_t state_q, state_d;
	logic [2:0] phase_q, phase_d;
	logic [IW-1:0] iter_q, iter_d;
	logic out_valid_q;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			iter_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			iter_q <= iter_d;
			if (cmd.op == OP_OUT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// sequencer
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		iter_d = iter_q;
		in_ready = 1'b0;
		cmd.op = OP_NONE;
		cmd.sel = phase_q;
		cmd.iter = ITER_W'(iter_q);
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_CAPTURE;
					state_d = in_tick ? ST_PREP : ST_OUT;
				end
			end
			ST_PREP: begin
				cmd.op = OP_PREP;
				phase_d = '0;
				state_d = ST_ROT_INIT;
			end
			ST_ROT_INIT: begin
				cmd.op = OP_ROT_INIT;
				iter_d = '0;
				state_d = ST_ROT_ITER;
			end
			ST_ROT_ITER: begin
				cmd.op = OP_ITER;
				iter_d = iter_q + 1'b1;
				if (iter_q == LAST_ITER) state_d = ST_ROT_DONE;
			end
			ST_ROT_DONE: begin
				cmd.op = OP_ROT_DONE;
				if (phase_q == PH_SINCOS_LAST) begin
					phase_d = '0;
					state_d = ST_MUL;
				end else begin
					phase_d = phase_q + 1'b1;
					state_d = ST_ROT_INIT;
				end
			end
			ST_MUL: begin
				cmd.op = OP_MUL;
				state_d = ST_MUL_WR;
			end
			ST_MUL_WR: begin
				cmd.op = OP_MUL_WR;
				if (phase_q == PH_MUL_W) begin
					phase_d = 3'd0;
					state_d = ST_VEC_INIT;
				end else if (phase_q == PH_MUL_HM) begin
					phase_d = 3'd1;
					state_d = ST_VEC_INIT;
				end else begin
					phase_d = phase_q + 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_VEC_INIT: begin
				cmd.op = OP_VEC_INIT;
				iter_d = '0;
				state_d = ST_VEC_ITER;
			end
			ST_VEC_ITER: begin
				cmd.op = OP_ITER;
				iter_d = iter_q + 1'b1;
				if (iter_q == LAST_ITER) state_d = ST_VEC_DONE;
			end
			ST_VEC_DONE: begin
				cmd.op = OP_VEC_DONE;
				if (phase_q == 3'd0) begin
					phase_d = PH_MUL_HM;
					state_d = ST_MUL;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.op = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/drps_datapath.sv
module drps_datapath #(
	parameter int CORDIC_STEPS = drps_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  drps_pkg::drps_cmd_t cmd,
	input  logic [31:0] load_lat,
	input  logic [31:0] load_lon,
	input  logic [15:0] speed_knots,
	input  logic [15:0] course_angle,
	input  logic in_tick,
	input  logic cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	output logic [31:0] lat_out,
	output logic [31:0] lon_out
);
	import drps_pkg::*;

	localparam int IW = $clog2(CORDIC_STEPS);

	typedef logic signed [DW-1:0] tab_t [CORDIC_STEPS];

	function automatic tab_t build_tab();
		tab_t t;
		for (int i = 0; i < CORDIC_STEPS; i++) t[i] = atan_entry(i);
		return t;
	endfunction

	localparam tab_t ATAN_TAB = build_tab();

	function automatic logic signed [DW-1:0] wrap32(input logic signed [DW-1:0] v);
		return {{(DW-32){v[31]}}, v[31:0]};
	endfunction

	logic [31:0] lat_q, lon_q;
	logic [15:0] gain_q;
	logic [15:0] spd_q, crs_q;
	logic [15:0] dist_q;
	logic [31:0] hdg_q;
	logic signed [DW-1:0] x_q, y_q, z_q;
	logic flip_q, vec_q, zero_q;
	logic signed [DW-1:0] cp_q, sp_q, cd_q, sd_q, cb_q, sb_q;
	logic signed [DW-1:0] sdcb_q, acc_q, v_q, u_q, w_q, dl_q, gm_q, hm_q;
	logic [63:0] prod_q;
	logic neg_q;
	logic [31:0] out_lat_q, out_lon_q;

	// CORDIC step terms
	logic [IW-1:0] sh;
	logic signed [DW-1:0] xs, ys, tab_i;
	logic dir;
	assign sh = cmd.iter[IW-1:0];
	assign xs = x_q >>> sh;
	assign ys = y_q >>> sh;
	assign tab_i = ATAN_TAB[sh];
	assign dir = vec_q ? y_q[DW-1] : !z_q[DW-1];

	// rotation start angle, wrapped and folded into +-90 degrees
	logic signed [DW-1:0] rot_src, rot_z;
	always_comb begin
		case (cmd.sel)
			3'd0: rot_src = {{(DW-32){lat_q[31]}}, lat_q};
			3'd1: rot_src = {{(DW-16){1'b0}}, dist_q};
			default: rot_src = {{(DW-32){1'b0}}, hdg_q};
		endcase
		rot_z = wrap32(rot_src);
	end

	// multiplier operand select
	logic signed [DW-1:0] ma, mb, abs_a, abs_b;
	always_comb begin
		case (cmd.sel)
			3'd0: begin ma = sd_q; mb = cb_q; end
			3'd1: begin ma = sp_q; mb = cd_q; end
			3'd2: begin ma = cp_q; mb = sdcb_q; end
			3'd3: begin ma = cp_q; mb = cd_q; end
			3'd4: begin ma = sp_q; mb = sdcb_q; end
			3'd5: begin ma = sd_q; mb = sb_q; end
			default: begin ma = gm_q; mb = KINV; end
		endcase
		abs_a = ma[DW-1] ? -ma : ma;
		abs_b = mb[DW-1] ? -mb : mb;
	end

	// truncated product, rounded toward zero
	logic signed [DW-1:0] mag_p, mres;
	assign mag_p = {{(DW-34){1'b0}}, prod_q[63:30]};
	assign mres = neg_q ? -mag_p : mag_p;

	// vectoring sources
	logic signed [DW-1:0] vx, vy;
	always_comb begin
		if (cmd.sel == 3'd0) begin
			vx = cp_q[DW-1] ? -u_q : u_q;
			vy = cp_q[DW-1] ? -w_q : w_q;
		end else begin
			vx = hm_q;
			vy = v_q;
		end
	end

	// position and gain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_q <= '0;
			lon_q <= '0;
			gain_q <= GAIN_RESET;
		end else begin
			if (cfg_wr_en) gain_q <= cfg_wr_data;
			if (cmd.op == OP_CAPTURE && !in_tick) begin
				lat_q <= load_lat;
				lon_q <= load_lon;
			end
			if (cmd.op == OP_VEC_DONE && cmd.sel != 3'd0) begin
				lat_q <= zero_q ? 32'd0 : z_q[31:0];
				lon_q <= lon_q + dl_q[31:0];
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				spd_q <= speed_knots;
				crs_q <= course_angle;
			end
			OP_PREP: begin
				dist_q <= 16'((32'(spd_q) * 32'(gain_q)) >> 16);
				hdg_q <= {crs_q, 16'd0};
			end
			OP_ROT_INIT: begin
				x_q <= KINV;
				y_q <= '0;
				vec_q <= 1'b0;
				if (rot_z > QUARTER_TURN) begin
					z_q <= rot_z - HALF_TURN;
					flip_q <= 1'b1;
				end else if (rot_z < NEG_QUARTER_TURN) begin
					z_q <= rot_z + HALF_TURN;
					flip_q <= 1'b1;
				end else begin
					z_q <= rot_z;
					flip_q <= 1'b0;
				end
			end
			OP_ITER: begin
				if (dir) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - tab_i;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + tab_i;
				end
			end
			OP_ROT_DONE: begin
				case (cmd.sel)
					3'd0: begin
						cp_q <= flip_q ? -x_q : x_q;
						sp_q <= flip_q ? -y_q : y_q;
					end
					3'd1: begin
						cd_q <= flip_q ? -x_q : x_q;
						sd_q <= flip_q ? -y_q : y_q;
					end
					default: begin
						cb_q <= flip_q ? -x_q : x_q;
						sb_q <= flip_q ? -y_q : y_q;
					end
				endcase
			end
			OP_MUL: begin
				prod_q <= 64'(abs_a[31:0]) * 64'(abs_b[31:0]);
				neg_q <= ma[DW-1] ^ mb[DW-1];
			end
			OP_MUL_WR: begin
				case (cmd.sel)
					3'd0: sdcb_q <= mres;
					3'd1: acc_q <= mres;
					3'd2: v_q <= acc_q + mres;
					3'd3: acc_q <= mres;
					3'd4: u_q <= acc_q - mres;
					3'd5: w_q <= mres;
					default: hm_q <= mres;
				endcase
			end
			OP_VEC_INIT: begin
				vec_q <= 1'b1;
				zero_q <= (vx == '0) && (vy == '0);
				if (vx[DW-1]) begin
					x_q <= -vx;
					y_q <= -vy;
					z_q <= HALF_TURN;
				end else begin
					x_q <= vx;
					y_q <= vy;
					z_q <= '0;
				end
			end
			OP_VEC_DONE: begin
				if (cmd.sel == 3'd0) begin
					dl_q <= (zero_q || cp_q == '0) ? '0 : wrap32(z_q);
					gm_q <= zero_q ? '0 : x_q;
				end
			end
			OP_OUT: begin
				out_lat_q <= lat_q;
				out_lon_q <= lon_q;
			end
			default: begin
			end
		endcase
	end

	assign lat_out = out_lat_q;
	assign lon_out = out_lon_q;

endmodule

>>> hdl/dead_reckoning_position_step_top.sv
// Load item: after accept the sequencer enters ST_OUT, which waits for the output register
// to free up and then registers the result. A tick item runs the single shared CORDIC unit
// five times and uses one multiplier seven times. One item in work at a time; a new item
// is taken while a result waits.
// arst_n clears the position to zero, distance_gain to 14131 and the sequencer.
module dead_reckoning_position_step_top #(
	parameter int CORDIC_STEPS = drps_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// [31:0] load_lat, [63:32] load_lon, [79:64] speed_knots, [95:80] course_angle
	input  logic [95:0] s_axis_tdata,
	// [0] cmd
	input  logic [0:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// [31:0] lat_out, [63:32] lon_out
	output logic [63:0] m_axis_tdata,
	input  logic cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);
	import drps_pkg::*;

	drps_cmd_t cmd;
	logic [31:0] lat_out, lon_out;

	drps_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_tick(s_axis_tuser[0]),
		.in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.cmd(cmd)
	);

	drps_datapath #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.load_lat(s_axis_tdata[31:0]),
		.load_lon(s_axis_tdata[63:32]),
		.speed_knots(s_axis_tdata[79:64]),
		.course_angle(s_axis_tdata[95:80]),
		.in_tick(s_axis_tuser[0]),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.lat_out(lat_out),
		.lon_out(lon_out)
	);

	assign m_axis_tdata = {lon_out, lat_out};

endmodule
